// ===== design/cca_pkg.sv =====
`default_nettype none
package cca_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ROUND = 2'd1,
        OP_SET   = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_RD,
        ST_IDX0,
        ST_IDX1,
        ST_IDX2,
        ST_IDX3,
        ST_IDX4,
        ST_RD0,
        ST_WR,
        ST_WR0,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } tod_t;

    localparam tod_t TOD_RESET = '{sec: 6'd0, min: 6'd0, hour: 5'd0,
                                   day: 5'd1, month: 4'd1, year: 7'd0};

    function automatic logic [4:0] days_in(input logic [6:0] y, input logic [3:0] m);
        logic [4:0] d;
        begin
            case (m)
                4'd2:                     d = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
                default:                  d = 5'd31;
            endcase
            return d;
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        begin
            case (m)
                4'd2:    d = 9'd31;
                4'd3:    d = 9'd59;
                4'd4:    d = 9'd90;
                4'd5:    d = 9'd120;
                4'd6:    d = 9'd151;
                4'd7:    d = 9'd181;
                4'd8:    d = 9'd212;
                4'd9:    d = 9'd243;
                4'd10:   d = 9'd273;
                4'd11:   d = 9'd304;
                4'd12:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

    // Carry the clock into the next minute, with second cleared.
    function automatic tod_t carry_minute(input tod_t t);
        tod_t r;
        begin
            r = t;
            r.sec = 6'd0;
            if (t.min >= 6'd59)
            begin
                r.min = 6'd0;
                if (t.hour >= 5'd23)
                begin
                    r.hour = 5'd0;
                    if (t.day >= days_in(t.year, t.month))
                    begin
                        r.day = 5'd1;
                        if (t.month >= 4'd12)
                        begin
                            r.month = 4'd1;
                            r.year = (t.year >= 7'd99) ? 7'd0 : t.year + 7'd1;
                        end
                        else
                        begin
                            r.month = t.month + 4'd1;
                        end
                    end
                    else
                    begin
                        r.day = t.day + 5'd1;
                    end
                end
                else
                begin
                    r.hour = t.hour + 5'd1;
                end
            end
            else
            begin
                r.min = t.min + 6'd1;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/cca_ram.sv =====
`default_nettype none
module cca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/cca_secidx.sv =====
`default_nettype none
// Second index of a calendar time, held in idx after registered steps for days,
// hours, minutes and seconds. The stages are pipelined, so a second start may follow in the next cycle.
module cca_secidx
    import cca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        start,
    input  wire tod_t        t,
    output logic      [31:0] idx
);
    logic [15:0] days_reg;
    logic [20:0] hours_reg;
    logic [31:0] idx_reg;
    logic [26:0] mins_reg;
    tod_t t1_reg;
    tod_t t2_reg;
    tod_t t3_reg;
    logic [15:0] days_next;
    logic [3:0]  m;

    always_comb
    begin
        m = (t.month >= 4'd1 && t.month <= 4'd12) ? t.month : 4'd1;
        days_next = 16'(t.year) * 16'd365 + 16'((t.year + 7'd3) >> 2)
                  + 16'(days_before(m))
                  + ((m > 4'd2 && t.year[1:0] == 2'd0) ? 16'd1 : 16'd0)
                  + 16'(t.day) - 16'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            days_reg <= days_next;
            t1_reg   <= t;
        end
        hours_reg <= 21'(days_reg) * 21'd24 + 21'(t1_reg.hour);
        t2_reg    <= t1_reg;
        mins_reg  <= 27'(hours_reg) * 27'd60 + 27'(t2_reg.min);
        t3_reg    <= t2_reg;
        idx_reg   <= 32'(mins_reg) * 32'd60 + 32'(t3_reg.sec);
    end

    assign idx = idx_reg;
endmodule
`default_nettype wire

// ===== design/clock_correction_accounting.sv =====
`default_nettype none
// Calendar clock with per-source correction statistics held in one
// synchronous RAM entry per source (four wrapping counters packed together).
// One request at a time: a tick, a query or a rejected set goes from the read
// state straight to the output state; a round from a valid non-zero source first
// checks its limit, and an accepted round or set does a read-modify-write of the
// source entry and then of the slot 0 entry, a set first running the four-stage
// second-index unit twice back to back. s_tready returns in the same cycle that
// the result is loaded, and the result waits while the previous one is not taken.
// After reset the RAM is cleared one entry at a time, during which
// s_tready is low.
module clock_correction_accounting
    import cca_pkg::*;
#(
    parameter int NUM_SOURCES = 10,
    parameter int ACC_WIDTH   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[1:0], source[5:2], second[11:6], minute[17:12], hour[22:18],
    // day[27:23], month[31:28], year[38:32], zero fill to 40 bits
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // accepted[0], out_second[6:1], out_minute[12:7], out_hour[17:13],
    // out_day[22:18], out_month[26:23], out_year[33:27], pos_total[49:34],
    // neg_total[65:50], pos_events[81:66], neg_events[97:82], zero fill to 104
    output logic [103:0]     m_tdata
);
    localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int EW = 4 * ACC_WIDTH;

    state_t state_reg, state_next;
    logic [15:0]    maxc_reg;
    tod_t           clk_reg, clk_next;
    logic [1:0]     op_reg;
    logic [3:0]     src_reg;
    tod_t           new_reg;
    logic [AW-1:0]  addr_reg, addr_next;
    logic           pos_reg, pos_next;
    logic           acc_reg, acc_next;
    logic [ACC_WIDTH-1:0] amt_reg, amt_next;
    logic [31:0]    d1_reg;
    logic [103:0]   out_reg, out_next;
    logic           ovalid_reg, ovalid_next;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [EW-1:0]  wdata, rdata;
    logic           idx_start;
    tod_t           idx_t;
    logic [31:0]    idx;
    logic           src_ok;
    logic [ACC_WIDTH-1:0] ps, ns_, pc, nc;
    logic           set_ok;
    logic [EW-1:0]  upd;

    cca_ram #(.WIDTH(EW), .DEPTH(NUM_SOURCES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    cca_secidx u_idx (.clk(clk), .start(idx_start), .t(idx_t), .idx(idx));

    assign src_ok = 32'(src_reg) < 32'(NUM_SOURCES);
    assign {nc, pc, ns_, ps} = rdata;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        set_ok = src_ok && src_reg != 4'd0 && new_reg.sec <= 6'd59
              && new_reg.min <= 6'd59 && new_reg.hour <= 5'd23
              && new_reg.month >= 4'd1 && new_reg.month <= 4'd12
              && new_reg.year <= 7'd99 && new_reg.day >= 5'd1
              && new_reg.day <= days_in(new_reg.year, new_reg.month);
        if (pos_reg)
        begin
            upd = {nc, pc + ACC_WIDTH'(1), ns_, ps + amt_reg};
        end
        else
        begin
            upd = {nc + ACC_WIDTH'(1), pc, ns_ + amt_reg, ps};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            maxc_reg   <= 16'd300;
            clk_reg    <= TOD_RESET;
            addr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clk_reg    <= clk_next;
            addr_reg   <= addr_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                maxc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[1:0];
            src_reg <= s_tdata[5:2];
            new_reg <= '{sec: s_tdata[11:6], min: s_tdata[17:12],
                         hour: s_tdata[22:18], day: s_tdata[27:23],
                         month: s_tdata[31:28], year: s_tdata[38:32]};
        end
        if (state_reg == ST_IDX3)
        begin
            d1_reg <= idx;
        end
        pos_reg <= pos_next;
        acc_reg <= acc_next;
        amt_reg <= amt_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        logic [ACC_WIDTH+16:0] sum;
        logic [31:0] diff;
        state_next  = state_reg;
        clk_next    = clk_reg;
        addr_next   = addr_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        amt_next    = amt_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        waddr       = addr_reg;
        wdata       = upd;
        raddr       = src_reg[AW-1:0];
        idx_start   = 1'b0;
        idx_t       = clk_reg;
        sum         = '0;
        diff        = '0;
        if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_CLR:
            begin
                we = 1'b1;
                wdata = '0;
                addr_next = addr_reg + AW'(1);
                if (32'(addr_reg) == NUM_SOURCES - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                // Source entry is read now; decide from the op code.
                acc_next = 1'b0;
                state_next = ST_WR;
                case (op_t'(op_reg))
                    OP_TICK:
                    begin
                        acc_next = 1'b1;
                        if (clk_reg.sec >= 6'd59)
                        begin
                            clk_next = carry_minute(clk_reg);
                        end
                        else
                        begin
                            clk_next.sec = clk_reg.sec + 6'd1;
                        end
                        state_next = ST_OUT;
                    end
                    OP_QUERY:
                    begin
                        acc_next = src_ok;
                        state_next = ST_OUT;
                    end
                    OP_SET:
                    begin
                        // The current time enters the index unit first.
                        idx_start = 1'b1;
                        state_next = set_ok ? ST_IDX0 : ST_OUT;
                    end
                    OP_ROUND:
                    begin
                        if (!(src_ok && src_reg != 4'd0))
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_WR:
            begin
                // Round: rdata holds the source entry.
                if (clk_reg.sec < 6'd30)
                begin
                    sum = (ACC_WIDTH+17)'(ns_) + (ACC_WIDTH+17)'(clk_reg.sec);
                    pos_next = 1'b0;
                    amt_next = ACC_WIDTH'(clk_reg.sec);
                end
                else
                begin
                    sum = (ACC_WIDTH+17)'(ps) + (ACC_WIDTH+17)'(clk_reg.sec);
                    pos_next = 1'b1;
                    amt_next = ACC_WIDTH'(7'd60 - 7'(clk_reg.sec));
                end
                if (sum <= (ACC_WIDTH+17)'(maxc_reg))
                begin
                    acc_next = 1'b1;
                    state_next = ST_RD0;
                    if (clk_reg.sec < 6'd30)
                    begin
                        clk_next.sec = 6'd0;
                    end
                    else
                    begin
                        clk_next = carry_minute(clk_reg);
                    end
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_IDX0:
            begin
                idx_start = 1'b1;
                idx_t = new_reg;
                state_next = ST_IDX1;
            end
            ST_IDX1:
            begin
                state_next = ST_IDX2;
            end
            ST_IDX2:
            begin
                state_next = ST_IDX3;
            end
            ST_IDX3:
            begin
                // idx now holds the current time's index.
                state_next = ST_IDX4;
            end
            ST_IDX4:
            begin
                // idx now holds the new time's index.
                if (idx > d1_reg)
                begin
                    pos_next = 1'b1;
                    diff = idx - d1_reg;
                end
                else
                begin
                    pos_next = 1'b0;
                    diff = d1_reg - idx;
                end
                amt_next = diff[ACC_WIDTH-1:0];
                acc_next = 1'b1;
                clk_next = new_reg;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                // Write the source entry back, read slot 0 next.
                we = 1'b1;
                waddr = src_reg[AW-1:0];
                raddr = '0;
                state_next = ST_WR0;
            end
            ST_WR0:
            begin
                we = 1'b1;
                waddr = '0;
                raddr = src_reg[AW-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // rdata holds the source entry after any update.
                if (!ovalid_reg || m_tready)
                begin
                    out_next = '0;
                    out_next[0] = acc_reg;
                    out_next[33:1] = {clk_reg.year, clk_reg.month, clk_reg.day,
                                      clk_reg.hour, clk_reg.min, clk_reg.sec};
                    if (src_ok)
                    begin
                        out_next[49:34] = 16'(ps);
                        out_next[65:50] = 16'(ns_);
                        out_next[81:66] = 16'(pc);
                        out_next[97:82] = 16'(nc);
                    end
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/cca_checker.sv =====
`default_nettype none
module cca_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata
);
    // A request is taken only when no other is in progress.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("overlapping requests");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    a_sec: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:1] <= 6'd59) else $error("second out of range");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[103:98] == 6'd0) else $error("fill bits set");
endmodule

bind clock_correction_accounting cca_checker u_cca_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
